[rtl/frame_group_timestamp_aligner_defines.svh]
// Assertion macros for the frame group timestamp aligner RTL.
// Expects the asserting module to have a clock named clk and a reset named rst.
`ifndef FRAME_GROUP_TIMESTAMP_ALIGNER_DEFINES_SVH
`define FRAME_GROUP_TIMESTAMP_ALIGNER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define FGTA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define FGTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fgta_pkg.sv]
// Shared types and constants for the frame group timestamp aligner.
// No dependencies; imported by every module of the block.
`default_nettype none

package fgta_pkg;

  // Number of source slots and derived index width.
  localparam int SLOT_COUNT   = 4;
  localparam int SLOT_IDX_W   = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  // Fixed field widths of the stream payloads.
  localparam int SLOT_FIELD_W = 2;
  localparam int TIME_W       = 64;
  localparam int CAMERA_W     = 8;
  localparam int HANDLE_W     = 8;
  localparam int STATUS_W     = 2;
  localparam int OUT_HANDLES  = 4;
  // Slots whose handles appear in a result.
  localparam int HANDLE_COUNT = (SLOT_COUNT < OUT_HANDLES) ? SLOT_COUNT : OUT_HANDLES;
  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_BITS      = SLOT_FIELD_W + TIME_W + CAMERA_W + HANDLE_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = STATUS_W + 3 * TIME_W + OUT_HANDLES * HANDLE_W + SLOT_FIELD_W;
  localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;
  // Reset value of the spread limit.
  localparam logic [TIME_W-1:0] SPREAD_RESET = TIME_W'(64'd10000000);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_WAIT  = 2'd0,
    ST_GROUP = 2'd1,
    ST_DROP  = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  // One arriving frame.
  typedef struct packed {
    logic [HANDLE_W-1:0]     frame_handle;
    logic [CAMERA_W-1:0]     source_camera;
    logic [TIME_W-1:0]       frame_timestamp;
    logic [SLOT_FIELD_W-1:0] slot_index;
  } item_t;

  // One result.
  typedef struct packed {
    logic [SLOT_FIELD_W-1:0]                dropped_slot;
    logic [OUT_HANDLES-1:0][HANDLE_W-1:0]   handles;
    logic [TIME_W-1:0]                      latest_time;
    logic [TIME_W-1:0]                      earliest_time;
    logic [TIME_W-1:0]                      group_number;
    status_t                                status;
  } result_t;

endpackage

`default_nettype wire

[rtl/frame_group_timestamp_aligner.sv]
// Top level of the frame group timestamp aligner: input register and handshake.
// Depends on fgta_pkg, fgta_slot_core and fgta_out_stage.
//
// Frames arrive one per transaction and fill one of four source slots; each
// arrival yields exactly one result (waiting, group emitted, oldest slot
// dropped, or duplicate cameras with all slots dropped). The block takes one
// transaction per clock cycle while the result register is free or being
// drained; each frame passes the input register, then the result register.
// The rate is set by the combinational evaluation in the slot core (merge of
// the new frame, four-way minimum and maximum, spread compare and the camera
// id compares), which updates the slot state with each evaluated frame. The
// user must write the spread limit through cfg_we and cfg_wdata only while
// no frame is in flight; the block itself does not enforce this.
`default_nettype none

module frame_group_timestamp_aligner (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fgta_pkg::TIME_W-1:0]     cfg_wdata,   // max_spread_ns
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // slot_index[1:0], frame_timestamp[65:2], source_camera[73:66],
  // frame_handle[81:74], zero padding above
  input  wire logic [fgta_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // status[1:0], group_number[65:2], earliest_time[129:66],
  // latest_time[193:130], handle_zero[201:194], handle_one[209:202],
  // handle_two[217:210], handle_three[225:218], dropped_slot[227:226], zero padding
  output logic [fgta_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import fgta_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t result;

  // The pipeline moves whenever the result register is free or being drained.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_tdata[IN_BITS-1:0];
    end
  end

  fgta_slot_core u_core (
    .clk       (clk),
    .rst       (rst),
    .eval_en   (in_valid && advance),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  fgta_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .load_valid (in_valid),
    .result     (result),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/fgta_slot_core.sv]
// Slot storage, group counter, spread limit and the combinational evaluation.
// Depends on fgta_pkg and frame_group_timestamp_aligner_defines.svh.
`default_nettype none
`include "frame_group_timestamp_aligner_defines.svh"

module fgta_slot_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          eval_en,
  input  wire fgta_pkg::item_t               item,
  input  wire logic                          cfg_we,
  input  wire logic [fgta_pkg::TIME_W-1:0]   cfg_wdata,
  output fgta_pkg::result_t                  result
);
  import fgta_pkg::*;

  logic [SLOT_COUNT-1:0]               slot_full;
  logic [SLOT_COUNT-1:0]               slot_full_next;
  logic [SLOT_COUNT-1:0][TIME_W-1:0]   slot_time;
  logic [SLOT_COUNT-1:0][CAMERA_W-1:0] slot_camera;
  logic [SLOT_COUNT-1:0][HANDLE_W-1:0] slot_handle;
  logic [TIME_W-1:0]                   group_counter;
  logic [TIME_W-1:0]                   max_spread_ns;

  logic                                in_range;
  logic [SLOT_COUNT-1:0]               hit;
  logic [SLOT_COUNT-1:0]               full_view;
  logic [SLOT_COUNT-1:0][TIME_W-1:0]   time_view;
  logic [SLOT_COUNT-1:0][CAMERA_W-1:0] camera_view;
  logic [SLOT_COUNT-1:0][HANDLE_W-1:0] handle_view;
  logic                                evaluate;
  logic                                dup;
  logic                                spread_ok;
  logic [TIME_W-1:0]                   lo;
  logic [TIME_W-1:0]                   hi;
  logic [SLOT_IDX_W-1:0]               oldest;

  // Slot contents as they stand once the arriving frame is written.
  always_comb begin
    in_range = int'(item.slot_index) < SLOT_COUNT;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]         = in_range && (int'(item.slot_index) == i);
      full_view[i]   = slot_full[i] | hit[i];
      time_view[i]   = hit[i] ? item.frame_timestamp : slot_time[i];
      camera_view[i] = hit[i] ? item.source_camera : slot_camera[i];
      handle_view[i] = hit[i] ? item.frame_handle : slot_handle[i];
    end
  end

  // Extremes, oldest slot (lowest index on ties) and duplicate camera check.
  always_comb begin
    lo     = time_view[0];
    hi     = time_view[0];
    oldest = '0;
    dup    = 1'b0;
    for (int i = 1; i < SLOT_COUNT; i++) begin
      if (time_view[i] < lo) begin
        lo     = time_view[i];
        oldest = SLOT_IDX_W'(i);
      end
      if (time_view[i] > hi) begin
        hi = time_view[i];
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      for (int j = i + 1; j < SLOT_COUNT; j++) begin
        if (camera_view[i] == camera_view[j]) begin
          dup = 1'b1;
        end
      end
    end
    spread_ok = (hi - lo) <= max_spread_ns;
    evaluate  = in_range && (max_spread_ns != '0) && (&full_view);
  end

  // Result and the next occupancy of the slots.
  always_comb begin
    result         = '0;
    result.status  = ST_WAIT;
    slot_full_next = slot_full;
    if (in_range) begin
      slot_full_next = full_view;
    end
    if (evaluate) begin
      result.earliest_time = lo;
      result.latest_time   = hi;
      if (dup) begin
        result.status  = ST_DUP;
        slot_full_next = '0;
      end else if (spread_ok) begin
        result.status       = ST_GROUP;
        result.group_number = group_counter + TIME_W'(1);
        for (int i = 0; i < HANDLE_COUNT; i++) begin
          result.handles[i] = handle_view[i];
        end
        slot_full_next = '0;
      end else begin
        result.status          = ST_DROP;
        result.dropped_slot    = SLOT_FIELD_W'(oldest);
        slot_full_next[oldest] = 1'b0;
      end
    end
  end

  // Control state: occupancy, group counter and spread limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full     <= '0;
      group_counter <= '0;
      max_spread_ns <= SPREAD_RESET;
    end else begin
      if (eval_en) begin
        slot_full <= slot_full_next;
        if (result.status == ST_GROUP) begin
          group_counter <= result.group_number;
        end
      end
      if (cfg_we) begin
        max_spread_ns <= cfg_wdata;
      end
    end
  end

  // Slot payload, written by the arriving frame only.
  always_ff @(posedge clk) begin
    if (eval_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (hit[i]) begin
          slot_time[i]   <= item.frame_timestamp;
          slot_camera[i] <= item.source_camera;
          slot_handle[i] <= item.frame_handle;
        end
      end
    end
  end

  `FGTA_ASSERT_NEXT(a_clear_after_set, eval_en && (result.status == ST_GROUP || result.status == ST_DUP), slot_full == '0, "slots not cleared after group or duplicate")
  `FGTA_ASSERT_NEXT(a_drop_one, eval_en && result.status == ST_DROP, $countones(slot_full) == SLOT_COUNT - 1, "oldest drop did not leave all but one slot full")
  `FGTA_ASSERT_NEXT(a_wait_keeps, eval_en && result.status == ST_WAIT && in_range, slot_full[$past(item.slot_index)], "arriving slot not marked full")
  `FGTA_ASSERT_SAME(a_group_spread, eval_en && result.status == ST_GROUP, (result.latest_time - result.earliest_time) <= max_spread_ns, "group spread above limit")

endmodule

`default_nettype wire

[rtl/fgta_out_stage.sv]
// Result register of the aligner: holds one result until the sink takes it.
// Depends on fgta_pkg for the result layout.
`default_nettype none

module fgta_out_stage (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire logic                              load_valid,
  input  wire fgta_pkg::result_t                 result,
  output logic                                   m_tvalid,
  output logic [fgta_pkg::OUT_DATA_W-1:0]        m_tdata
);
  import fgta_pkg::*;

  result_t held;

  // Valid flag follows the pipeline advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= load_valid;
    end
  end

  // Payload is captured only with a new transaction.
  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      held <= result;
    end
  end

  // Pack the fields from status upward and pad to whole bytes.
  assign m_tdata = OUT_DATA_W'(held);

endmodule

`default_nettype wire

[dv/frame_group_timestamp_aligner_tb.sv]
// Self-checking testbench for frame_group_timestamp_aligner: streams frame arrivals,
// predicts each status result in a scoreboard class and compares them field by field.
// Depends on fgta_pkg and the frame_group_timestamp_aligner RTL.
module frame_group_timestamp_aligner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fgta_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_SETS  = 8;
  localparam int ITEMS_PER_SET = 80;

  // Scoreboard: tracks the pending slots and queues the predicted results.
  class frame_group_scoreboard;
    logic [TIME_W-1:0]   spread_limit;
    bit                  occupied[SLOT_COUNT];
    logic [TIME_W-1:0]   stamp[SLOT_COUNT];
    logic [CAMERA_W-1:0] camera[SLOT_COUNT];
    logic [HANDLE_W-1:0] handle[SLOT_COUNT];
    logic [TIME_W-1:0]   group_count;
    result_t             awaited_results[$];
    int                  mismatches;

    function new();
      spread_limit = SPREAD_RESET;
      group_count  = '0;
      mismatches   = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void clear_slots();
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    // Store the arriving frame and work out the status it causes.
    function void note_arrival(item_t f);
      result_t           r;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
      int                oldest;
      int                s;
      bit                full_set;
      bit                dup_cam;
      r = '0;
      r.status = ST_WAIT;
      s = int'(f.slot_index);
      if (s >= SLOT_COUNT) begin
        awaited_results.push_back(r);
        return;
      end
      occupied[s] = 1'b1;
      stamp[s]    = f.frame_timestamp;
      camera[s]   = f.source_camera;
      handle[s]   = f.frame_handle;
      // A zero spread limit stores the frame but never evaluates the slots.
      if (spread_limit == '0) begin
        awaited_results.push_back(r);
        return;
      end
      full_set = 1'b1;
      foreach (occupied[i]) if (!occupied[i]) full_set = 1'b0;
      if (!full_set) begin
        awaited_results.push_back(r);
        return;
      end
      lo = '1;
      hi = '0;
      oldest = 0;
      dup_cam = 1'b0;
      // On equal timestamps the strict compare keeps the lowest slot as oldest.
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (stamp[i] < lo) begin
          lo = stamp[i];
          oldest = i;
        end
        if (stamp[i] > hi) hi = stamp[i];
        for (int j = i + 1; j < SLOT_COUNT; j++)
          if (camera[i] == camera[j]) dup_cam = 1'b1;
      end
      r.earliest_time = lo;
      r.latest_time   = hi;
      if (dup_cam) begin
        clear_slots();
        r.status = ST_DUP;
      end else if (hi - lo <= spread_limit) begin
        group_count = group_count + 1'b1;
        r.status = ST_GROUP;
        r.group_number = group_count;
        for (int i = 0; i < HANDLE_COUNT; i++) r.handles[i] = handle[i];
        clear_slots();
      end else begin
        occupied[oldest] = 1'b0;
        r.status = ST_DROP;
        r.dropped_slot = SLOT_FIELD_W'(oldest);
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // Compare one output transaction with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no frame pending: %h", got);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("group_number", want.group_number, got.group_number);
      compare_field("earliest_time", want.earliest_time, got.earliest_time);
      compare_field("latest_time", want.latest_time, got.latest_time);
      compare_field("handle_zero", 64'(want.handles[0]), 64'(got.handles[0]));
      compare_field("handle_one", 64'(want.handles[1]), 64'(got.handles[1]));
      compare_field("handle_two", 64'(want.handles[2]), 64'(got.handles[2]));
      compare_field("handle_three", 64'(want.handles[3]), 64'(got.handles[3]));
      compare_field("dropped_slot", 64'(want.dropped_slot), 64'(got.dropped_slot));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [TIME_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  frame_group_scoreboard board;
  int burst_left = 0;
  int items_sent = 0;
  int cycles = 0;
  int ready_tick = 0;

  frame_group_timestamp_aligner uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("frame_group_timestamp_aligner verification failed");
      $finish;
    end
  end

  // Sample both streams at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_arrival(item_t'(s_tdata[IN_BITS-1:0]));
      if (m_tvalid && m_tready) board.check_result(result_t'(m_tdata[OUT_BITS-1:0]));
    end
  end

  // Result-side back-pressure cycles through four ready patterns.
  always @(negedge clk) begin
    ready_tick++;
    case ((ready_tick / 128) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (ready_tick % 4 == 0);
      default: m_tready <= (ready_tick % 32 < 3);
    endcase
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one frame, inserting a random gap between bursts.
  task automatic send_frame(input int slot, input logic [63:0] ts, input logic [7:0] cam,
                            input logic [7:0] hdl);
    item_t f;
    int    gap;
    f.slot_index      = SLOT_FIELD_W'(slot);
    f.frame_timestamp = ts;
    f.source_camera   = cam;
    f.frame_handle    = hdl;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(f);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_spread(input logic [63:0] limit);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.spread_limit = limit;
  endtask

  // Mostly complete slot sets with random content, mixed with stray frames.
  task automatic run_random_sets(input int count);
    logic [63:0] base;
    logic [63:0] lim;
    logic [63:0] off;
    logic [7:0]  cams[4];
    logic [7:0]  c0;
    int          order[4];
    int          kind, i, j, t, step, start;
    start = items_sent;
    while (items_sent - start < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        case ($urandom_range(0, 5))
          0: base = '0;
          1: base = '1 - 64'($urandom_range(0, 1000));
          default: base = rand64();
        endcase
        lim = (kind <= 3) ? board.spread_limit : board.spread_limit << 1;
        c0 = 8'($urandom);
        step = $urandom_range(1, 63);
        for (i = 0; i < 4; i++) begin
          cams[i] = c0 + 8'(i * step);
          order[i] = i;
        end
        if (kind == 6) begin
          i = $urandom_range(0, 3);
          j = (i + $urandom_range(1, 3)) % 4;
          cams[j] = cams[i];
        end
        for (i = 3; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (t = 0; t < 4; t++) begin
          if ($urandom_range(0, 9) == 0)
            send_frame(order[t], rand64(), 8'($urandom), 8'($urandom));
          off = (lim == '0) ? rand64() : rand64() % lim;
          send_frame(order[t], base + off, cams[t], 8'($urandom));
        end
      end else begin
        send_frame($urandom_range(0, 3), rand64(), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [63:0] limit;
    board = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: a clean group under the reset limit.
    send_frame(0, 64'd1000, 8'd1, 8'h00);
    send_frame(1, 64'd1005, 8'd2, 8'hff);
    send_frame(2, 64'd1010, 8'd3, 8'h5a);
    send_frame(3, 64'd1020, 8'd4, 8'ha5);
    // A second arrival for a full slot replaces the first.
    send_frame(2, 64'd50, 8'd9, 8'h11);
    send_frame(2, 64'd2000, 8'd10, 8'h22);
    send_frame(0, 64'd2001, 8'd11, 8'h33);
    send_frame(1, 64'd2002, 8'd12, 8'h44);
    send_frame(3, 64'd2003, 8'd13, 8'h55);
    // Two slots report the same camera.
    send_frame(0, 64'd3000, 8'd7, 8'h01);
    send_frame(1, 64'd3001, 8'd8, 8'h02);
    send_frame(2, 64'd3002, 8'd7, 8'h03);
    send_frame(3, 64'd3003, 8'd9, 8'h04);
    // Spread too wide; the tie on the smallest time drops the lower slot.
    send_frame(3, 64'd5, 8'd1, 8'h10);
    send_frame(1, 64'd5, 8'd2, 8'h20);
    send_frame(0, '1, 8'd3, 8'h30);
    send_frame(2, 64'h8000_0000_0000_0000, 8'd4, 8'h40);
    send_frame(1, '1, 8'd5, 8'h50);
    // Widest limit accepts the full timestamp range.
    write_spread('1);
    send_frame(3, '0, 8'd0, 8'hff);
    // Narrowest limit with all timestamps at their maximum.
    write_spread(64'd1);
    send_frame(0, '1, 8'd0, 8'h00);
    send_frame(1, '1, 8'd255, 8'hff);
    send_frame(2, '1, 8'd1, 8'h0f);
    send_frame(3, '1, 8'd254, 8'hf0);
    // A zero limit only stores frames.
    write_spread('0);
    send_frame(0, 64'd77, 8'd6, 8'h66);
    send_frame(1, 64'd78, 8'd6, 8'h67);

    // Random phases, each under its own spread limit.
    for (int p = 0; p < RANDOM_SETS; p++) begin
      case (p % 6)
        0: limit = 64'd10000000;
        1: limit = '1;
        2: limit = 64'd1;
        3: limit = 64'($urandom_range(2, 5000));
        4: limit = (rand64() >> $urandom_range(0, 40)) | 64'd1;
        default: limit = rand64() | 64'd1;
      endcase
      write_spread(limit);
      run_random_sets(ITEMS_PER_SET);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("frame_group_timestamp_aligner verification clean");
    end else begin
      $display("frame_group_timestamp_aligner verification failed");
    end
    $finish;
  end
endmodule
